@@ rtl/core/rsrt_pkg.sv @@
// rsrt_pkg: constants, payload types and controller/datapath interface types
// for the rhythm slot regularity tracker. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rsrt_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int COUNT_BITS = 8;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int SUM_W      = COUNT_BITS + SLOT_W;
    localparam int CNT_W      = SLOT_W + 1;
    localparam int NUM_W      = SUM_W + 1;
    localparam int DEN_W      = CNT_W + 1;
    localparam int DCNT_W     = $clog2(NUM_W + 1);
    localparam int ADD_W      = COUNT_BITS + 9;
    localparam int PROD_W     = 16 + COUNT_BITS;
    localparam int CFG_IDX_W  = 1;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_CLEAR  = 2'd1;
    localparam logic [1:0] REQ_SMOOTH = 2'd2;
    localparam logic [1:0] REQ_STEP   = 2'd3;

    localparam logic [1:0] CASE_NONE   = 2'd0;
    localparam logic [1:0] CASE_EMPTY  = 2'd1;
    localparam logic [1:0] CASE_HIT    = 2'd2;
    localparam logic [1:0] CASE_MISSED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVATION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO      = 1'd1;

    typedef struct packed {
        logic [1:0] req_type;
        logic [3:0] slot_index;
        logic [7:0] hit_amount;
    } rsrt_in_t;

    typedef struct packed {
        logic [7:0]  smoothed_mean;
        logic [7:0]  raw_mean;
        logic        entry_dismissed;
        logic        is_active;
        logic [15:0] regularity_score;
        logic [1:0]  step_case;
    } rsrt_out_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic sweep1;
        logic sweep2;
        logic div_load;
        logic div_second;
        logic div_step;
        logic fin_raw;
        logic fin_mean;
        logic out_load;
    } rsrt_cmd_t;

    typedef struct packed {
        logic       last;
        logic       div_done;
        logic [1:0] req_type;
    } rsrt_status_t;

endpackage
`default_nettype wire

@@ rtl/core/rsrt_ctrl.sv @@
// rsrt_ctrl: sequencing state machine for the tracker.
// Depends on rsrt_pkg; drives commands into rsrt_datapath.
`timescale 1ns / 1ps
`default_nettype none
module rsrt_ctrl
    import rsrt_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  wire logic         m_ready,
    input  wire rsrt_status_t status,
    output rsrt_cmd_t         cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_EXEC = 4'd1;
    localparam logic [3:0] ST_SWP1 = 4'd2;
    localparam logic [3:0] ST_DLD1 = 4'd3;
    localparam logic [3:0] ST_DIV1 = 4'd4;
    localparam logic [3:0] ST_SWP2 = 4'd5;
    localparam logic [3:0] ST_DLD2 = 4'd6;
    localparam logic [3:0] ST_DIV2 = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (status.req_type == REQ_SMOOTH) begin
                    state_next = ST_SWP1;
                end else begin
                    cmd.exec   = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_SWP1: begin
                cmd.sweep1 = 1'b1;
                if (status.last) state_next = ST_DLD1;
            end
            ST_DLD1: begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV1;
            end
            ST_DIV1: begin
                if (status.div_done) begin
                    cmd.fin_raw = 1'b1;
                    state_next  = ST_SWP2;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_SWP2: begin
                cmd.sweep2 = 1'b1;
                if (status.last) state_next = ST_DLD2;
            end
            ST_DLD2: begin
                cmd.div_load   = 1'b1;
                cmd.div_second = 1'b1;
                state_next     = ST_DIV2;
            end
            ST_DIV2: begin
                if (status.div_done) begin
                    cmd.fin_mean = 1'b1;
                    state_next   = ST_OUT;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/rsrt_datapath.sv @@
// rsrt_datapath: slot histogram, reference copy, score, config registers,
// sweep accumulators, shared iterative divider and output register. Uses rsrt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rsrt_datapath
    import rsrt_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire rsrt_in_t             s_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data,
    input  wire rsrt_cmd_t            cmd,
    output rsrt_status_t              status,
    output rsrt_out_t                 m_data
);

    localparam logic [COUNT_BITS-1:0] SLOT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [SLOT_W-1:0]     LAST_IX  = SLOT_W'(SLOT_COUNT - 1);

    logic [COUNT_BITS-1:0] hit_reg [SLOT_COUNT];
    logic [COUNT_BITS-1:0] ref_reg [SLOT_COUNT];
    logic [7:0]            mean_reg;
    logic [15:0]           score_reg;
    logic [7:0]            act_reg;
    logic [15:0]           lim_reg;
    rsrt_in_t              req_reg;
    logic [SLOT_W-1:0]     addr_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [COUNT_BITS-1:0] peak_reg;
    logic [7:0]            raw_reg;
    logic                  dis_reg;
    logic [1:0]            case_reg;
    logic [NUM_W-1:0]      num_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [DEN_W-1:0]      rem_reg;
    logic [DCNT_W-1:0]     dcnt_reg;
    rsrt_out_t             out_reg;

    logic                  slot_ok;
    logic [SLOT_W-1:0]     slot_ix;
    logic [SLOT_W-1:0]     prev_ix;
    logic                  low_mean;
    logic [SLOT_W-1:0]     ex_ix;
    logic [SLOT_W-1:0]     rd_ix;
    logic [COUNT_BITS-1:0] rd_hit;
    logic [COUNT_BITS-1:0] rd_ref;
    logic [ADD_W-1:0]      add_sum;
    logic [COUNT_BITS-1:0] add_val;
    logic                  kill;
    logic [PROD_W-1:0]     lim_prod;
    logic [DEN_W:0]        div_t;
    logic                  div_bit;
    logic [7:0]            quo_sat;

    assign slot_ok  = 32'(req_reg.slot_index) < SLOT_COUNT;
    assign slot_ix  = SLOT_W'(req_reg.slot_index);
    assign prev_ix  = (slot_ix == '0) ? LAST_IX : slot_ix - 1'b1;
    assign low_mean = mean_reg < act_reg;
    assign ex_ix    = (req_reg.req_type == REQ_STEP && !low_mean) ? prev_ix : slot_ix;
    assign rd_ix    = cmd.exec ? ex_ix : addr_reg;
    assign rd_hit   = hit_reg[rd_ix];
    assign rd_ref   = ref_reg[rd_ix];

    assign add_sum  = ADD_W'(rd_hit) + ADD_W'(req_reg.hit_amount);
    assign add_val  = (add_sum > ADD_W'(SLOT_MAX)) ? SLOT_MAX : add_sum[COUNT_BITS-1:0];

    assign lim_prod = PROD_W'(lim_reg) * PROD_W'(peak_reg);
    assign kill     = (rd_hit != '0)
                   && (((COUNT_BITS + 2)'(rd_hit) * (COUNT_BITS + 2)'(3))
                           < (COUNT_BITS + 2)'(peak_reg)
                       || (PROD_W'(rd_hit) << 8) > lim_prod);

    assign div_t    = {rem_reg, num_reg[NUM_W-1]};
    assign div_bit  = div_t >= (DEN_W + 1)'(den_reg);
    assign quo_sat  = (den_reg == '0) ? 8'd0
                    : (num_reg > NUM_W'(255)) ? 8'd255 : num_reg[7:0];

    assign status.last     = (addr_reg == LAST_IX);
    assign status.div_done = (dcnt_reg == '0);
    assign status.req_type = req_reg.req_type;
    assign m_data          = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                hit_reg[i] <= '0;
                ref_reg[i] <= '0;
            end
            mean_reg  <= '0;
            score_reg <= '0;
            act_reg   <= 8'd4;
            lim_reg   <= 16'hFFFF;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_ACTIVATION: act_reg <= cfg_data[7:0];
                    CFG_RATIO:      lim_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.exec) begin
                unique case (req_reg.req_type)
                    REQ_ADD: begin
                        if (slot_ok) hit_reg[rd_ix] <= add_val;
                    end
                    REQ_CLEAR: begin
                        for (int i = 0; i < SLOT_COUNT; i++) hit_reg[i] <= '0;
                    end
                    REQ_STEP: begin
                        if (slot_ok) begin
                            ref_reg[rd_ix] <= rd_hit;
                            if (!low_mean) begin
                                if ((rd_hit == '0 && rd_ref == '0) || rd_hit > rd_ref) begin
                                    if (score_reg != 16'hFFFF) score_reg <= score_reg + 1'b1;
                                end else if (rd_hit != '0) begin
                                    if (score_reg != '0) score_reg <= score_reg - 1'b1;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
            if (cmd.sweep2 && kill) hit_reg[rd_ix] <= '0;
            if (cmd.fin_mean) mean_reg <= quo_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg  <= s_data;
            addr_reg <= '0;
            sum_reg  <= '0;
            cnt_reg  <= '0;
            peak_reg <= '0;
            raw_reg  <= '0;
            dis_reg  <= 1'b0;
            case_reg <= CASE_NONE;
            dcnt_reg <= '0;
        end
        if (cmd.exec && req_reg.req_type == REQ_STEP && slot_ok && !low_mean) begin
            priority if (rd_hit == '0 && rd_ref == '0) begin
                case_reg <= CASE_EMPTY;
            end else if (rd_hit != '0 && rd_hit > rd_ref) begin
                case_reg <= CASE_HIT;
            end else if (rd_hit != '0) begin
                case_reg <= CASE_MISSED;
            end else begin
                case_reg <= CASE_NONE;
            end
        end
        if (cmd.sweep1) begin
            addr_reg <= addr_reg + 1'b1;
            if (rd_hit != '0) begin
                cnt_reg <= cnt_reg + 1'b1;
                sum_reg <= sum_reg + SUM_W'(rd_hit);
                if (rd_hit > peak_reg) peak_reg <= rd_hit;
            end
        end
        if (cmd.sweep2) begin
            addr_reg <= addr_reg + 1'b1;
            if (kill) begin
                dis_reg <= 1'b1;
            end else if (rd_hit != '0) begin
                cnt_reg <= cnt_reg + 1'b1;
                sum_reg <= sum_reg + SUM_W'(rd_hit);
            end
        end
        if (cmd.div_load) begin
            if (cmd.div_second) begin
                num_reg <= {sum_reg, 1'b0} + NUM_W'(cnt_reg);
                den_reg <= {cnt_reg, 1'b0};
            end else begin
                num_reg <= NUM_W'(sum_reg);
                den_reg <= DEN_W'(cnt_reg);
            end
            rem_reg  <= '0;
            dcnt_reg <= DCNT_W'(NUM_W);
            sum_reg  <= '0;
            cnt_reg  <= '0;
            addr_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_reg  <= div_bit ? DEN_W'(div_t - (DEN_W + 1)'(den_reg)) : div_t[DEN_W-1:0];
            num_reg  <= {num_reg[NUM_W-2:0], div_bit};
            dcnt_reg <= dcnt_reg - 1'b1;
        end
        if (cmd.fin_raw) raw_reg <= quo_sat;
        if (cmd.out_load) begin
            out_reg.smoothed_mean    <= mean_reg;
            out_reg.raw_mean         <= raw_reg;
            out_reg.entry_dismissed  <= dis_reg;
            out_reg.is_active        <= mean_reg > act_reg;
            out_reg.regularity_score <= score_reg;
            out_reg.step_case        <= case_reg;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/rhythm_slot_regularity_tracker_unit.sv @@
// rhythm_slot_regularity_tracker_unit: top level, joins rsrt_ctrl and rsrt_datapath.
// Depends on rsrt_pkg, rsrt_ctrl, rsrt_datapath.
//
// Usage:
//   s_valid/s_ready/s_data carry one request (add hits, clear, smooth, step).
//   m_valid/m_ready/m_data return exactly one result per request.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write activation level (index 0)
//   or ratio limit (index 1); cfg_ready is always high, write only when idle.
//   Add, clear and step go from accept through the EXEC and OUT states to m_valid.
//   Smooth makes two 16-slot sweeps through one histogram read port, each
//   followed by a 13-step restoring divide, first for the raw mean and then
//   for the smoothed mean.
//   One request is processed at a time; s_ready is high only while idle.
//   The result sits in an output register, so a new request is accepted
//   while the previous result waits; if the receiver stalls, the next
//   result waits in the controller until the output register frees.
//   Reset (aresetn low, synchronous) clears histogram, reference, mean and
//   score, sets activation level 4 and ratio limit 65535, drops m_valid.
`timescale 1ns / 1ps
`default_nettype none
module rhythm_slot_regularity_tracker_unit
    import rsrt_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire rsrt_in_t             s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output rsrt_out_t                 m_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data
);

    rsrt_cmd_t    cmd;
    rsrt_status_t status;

    assign cfg_ready = 1'b1;

    rsrt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rsrt_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

@@ tb/rhythm_slot_regularity_tracker_unit_tb.sv @@
// rhythm_slot_regularity_tracker_unit_tb: self-checking bench for the slot regularity tracker.
// Drives requests and configuration writes, predicts each result and compares it.
// Depends on rsrt_pkg and rhythm_slot_regularity_tracker_unit.
`timescale 1ns / 1ps
module rhythm_slot_regularity_tracker_unit_tb;
    import rsrt_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    rsrt_in_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    rsrt_out_t            m_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    logic [7:0]  hist_model [SLOT_COUNT];
    logic [7:0]  ref_model [SLOT_COUNT];
    logic [7:0]  mean_model;
    logic [15:0] score_model;
    logic [7:0]  act_level;
    logic [15:0] ratio_lim;

    rsrt_out_t result_queue[$];
    int        mismatch_count;
    int        idle_cycles;
    bit        hold_off;
    bit        timed_out;

    rhythm_slot_regularity_tracker_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    function automatic rsrt_out_t tracker_predict(rsrt_in_t rq);
        rsrt_out_t  o;
        logic [8:0]  added;
        int unsigned sum, n, peak, a;
        logic [3:0]  p;
        logic [7:0]  h, r;
        o = '0;
        case (rq.req_type)
            REQ_ADD: begin
                added = hist_model[rq.slot_index] + rq.hit_amount;
                hist_model[rq.slot_index] = added > 255 ? 8'd255 : added[7:0];
            end
            REQ_CLEAR: begin
                for (int j = 0; j < SLOT_COUNT; j++) hist_model[j] = '0;
            end
            REQ_SMOOTH: begin
                sum = 0; n = 0; peak = 0;
                for (int j = 0; j < SLOT_COUNT; j++) begin
                    if (hist_model[j] > 0) begin
                        n++;
                        sum += hist_model[j];
                        if (hist_model[j] > peak) peak = hist_model[j];
                    end
                end
                if (n != 0) o.raw_mean = (sum / n) > 255 ? 8'd255 : 8'(sum / n);
                for (int j = 0; j < SLOT_COUNT; j++) begin
                    a = hist_model[j];
                    if (a > 0 && (3 * a < peak || 64'(256 * a) > 64'(ratio_lim) * peak)) begin
                        hist_model[j] = '0;
                        o.entry_dismissed = 1'b1;
                    end
                end
                sum = 0; n = 0;
                for (int j = 0; j < SLOT_COUNT; j++) begin
                    if (hist_model[j] > 0) begin
                        n++;
                        sum += hist_model[j];
                    end
                end
                if (n == 0) mean_model = '0;
                else if ((2 * sum + n) / (2 * n) > 255) mean_model = 8'd255;
                else mean_model = 8'((2 * sum + n) / (2 * n));
            end
            default: begin
                if (mean_model < act_level) begin
                    ref_model[rq.slot_index] = hist_model[rq.slot_index];
                end else begin
                    p = rq.slot_index - 4'd1;
                    h = hist_model[p];
                    r = ref_model[p];
                    if (h == 0 && r == 0) begin
                        if (score_model != 16'hffff) score_model++;
                        o.step_case = CASE_EMPTY;
                    end else if (h > 0 && h > r) begin
                        if (score_model != 16'hffff) score_model++;
                        o.step_case = CASE_HIT;
                    end else if (h > 0) begin
                        if (score_model != 0) score_model--;
                        o.step_case = CASE_MISSED;
                    end
                    ref_model[p] = h;
                end
            end
        endcase
        o.smoothed_mean = mean_model;
        o.is_active = mean_model > act_level;
        o.regularity_score = score_model;
        return o;
    endfunction

    task automatic send_request(rsrt_in_t rq);
        repeat (gap_len() + 1) @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= rq;
        do @(posedge aclk); while (!s_ready);
        result_queue.push_back(tracker_predict(rq));
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        wait (result_queue.size() == 0);
        repeat (80) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_ACTIVATION) act_level = val[7:0];
        else ratio_lim = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic rsrt_in_t make_req(logic [1:0] t, logic [3:0] s, logic [7:0] a);
        rsrt_in_t rq;
        rq.req_type = t;
        rq.slot_index = s;
        rq.hit_amount = a;
        return rq;
    endfunction

    function automatic rsrt_in_t random_req();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return make_req(REQ_ADD, 4'($urandom), 8'($urandom_range(0, 40)));
        if (r < 50) return make_req(REQ_ADD, 4'($urandom), 8'($urandom));
        if (r < 55) return make_req(REQ_CLEAR, 4'($urandom), 8'($urandom));
        if (r < 65) return make_req(REQ_SMOOTH, 4'($urandom), 8'($urandom));
        return make_req(REQ_STEP, 4'($urandom), 8'($urandom));
    endfunction

    task automatic test_directed();
        send_request(make_req(REQ_SMOOTH, 4'd0, 8'd0));
        send_request(make_req(REQ_STEP, 4'd0, 8'd0));
        send_request(make_req(REQ_ADD, 4'd0, 8'd255));
        send_request(make_req(REQ_ADD, 4'd0, 8'd255));
        send_request(make_req(REQ_ADD, 4'd15, 8'd200));
        send_request(make_req(REQ_ADD, 4'd7, 8'd10));
        send_request(make_req(REQ_ADD, 4'd3, 8'd100));
        send_request(make_req(REQ_SMOOTH, 4'd15, 8'hff));
        send_request(make_req(REQ_STEP, 4'd0, 8'd0));
        send_request(make_req(REQ_STEP, 4'd1, 8'd0));
        send_request(make_req(REQ_STEP, 4'd1, 8'd0));
        send_request(make_req(REQ_STEP, 4'd8, 8'd0));
        send_request(make_req(REQ_ADD, 4'd0, 8'd1));
        send_request(make_req(REQ_STEP, 4'd1, 8'd0));
        send_request(make_req(REQ_CLEAR, 4'd0, 8'd0));
        send_request(make_req(REQ_STEP, 4'd1, 8'd0));
        send_request(make_req(REQ_STEP, 4'd4, 8'd0));
        send_request(make_req(REQ_SMOOTH, 4'd0, 8'd0));
    endtask

    task automatic test_config_extremes();
        write_register(CFG_ACTIVATION, 16'd0);
        write_register(CFG_RATIO, 16'd0);
        send_request(make_req(REQ_ADD, 4'd2, 8'd50));
        send_request(make_req(REQ_ADD, 4'd5, 8'd60));
        send_request(make_req(REQ_SMOOTH, 4'd0, 8'd0));
        write_register(CFG_RATIO, 16'd256);
        send_request(make_req(REQ_SMOOTH, 4'd0, 8'd0));
        write_register(CFG_ACTIVATION, 16'hffff);
        send_request(make_req(REQ_STEP, 4'd3, 8'd0));
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) send_request(random_req());
    endtask

    task automatic test_back_pressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(negedge aclk);
                hold_off = 1'b0;
            end
        join_none
        for (int i = 0; i < 12; i++)
            send_request(make_req(REQ_ADD, 4'($urandom), 8'($urandom)));
    endtask

    task automatic test_score_saturation();
        write_register(CFG_ACTIVATION, 16'd0);
        send_request(make_req(REQ_CLEAR, 4'd0, 8'd0));
        for (int i = 0; i < 60; i++) send_request(make_req(REQ_STEP, 4'($urandom), 8'd0));
    endtask

    always @(negedge aclk) begin
        if (!aresetn || hold_off) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(0, 99) < 70);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (result_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result %h", m_data);
            end else if (m_data !== result_queue[0]) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("mismatch expected %h actual %h", result_queue[0], m_data);
                void'(result_queue.pop_front());
            end else begin
                void'(result_queue.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_off = 1'b0;
        timed_out = 1'b0;
        mismatch_count = 0;
        idle_cycles = 0;
        for (int j = 0; j < SLOT_COUNT; j++) begin
            hist_model[j] = '0;
            ref_model[j] = '0;
        end
        mean_model = '0;
        score_model = '0;
        act_level = 8'd4;
        ratio_lim = 16'hffff;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_config_extremes();
        test_back_pressure();
        write_register(CFG_ACTIVATION, 16'd4);
        write_register(CFG_RATIO, 16'hffff);
        test_random(300);
        write_register(CFG_ACTIVATION, 16'($urandom_range(0, 30)));
        write_register(CFG_RATIO, 16'($urandom_range(256, 1024)));
        test_random(300);
        test_score_saturation();
        write_register(CFG_ACTIVATION, 16'd2);
        write_register(CFG_RATIO, 16'($urandom));
        test_random(150);

        wait (result_queue.size() == 0);
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0 && result_queue.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

@@ rhythm_slot_regularity_tracker_unit.f @@
rtl/core/rsrt_pkg.sv
rtl/core/rsrt_ctrl.sv
rtl/core/rsrt_datapath.sv
rtl/core/rhythm_slot_regularity_tracker_unit.sv
tb/rhythm_slot_regularity_tracker_unit_tb.sv
